// File: hdl/biu_pkg.sv
package biu_pkg;

	localparam int DIM_W = 13;
	localparam int COORD_W = 12;
	localparam int DIV_W = 13;
	localparam int PIX_W = 24;

	localparam logic CFG_OUT_WIDTH = 1'b0;
	localparam logic CFG_OUT_HEIGHT = 1'b1;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic [DIM_W-1:0] RESET_OUT_WIDTH = 13'd320;
	localparam logic [DIM_W-1:0] RESET_OUT_HEIGHT = 13'd240;

	typedef struct packed {
		logic kind;
		logic [8:0] src_col;
		logic [7:0] src_row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
	} item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} result_t;

	// Everything that rides alongside the coordinate divider.
	typedef struct packed {
		logic kind;
		logic [8:0] src_col;
		logic [7:0] src_row;
		logic [PIX_W-1:0] pixel;
		logic lastx;
		logic lasty;
	} side_t;

endpackage

// File: hdl/biu_ram.sv
module biu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 19200
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/biu_map.sv
module biu_map import biu_pkg::*; #(
	parameter int QW = 17,
	parameter int NXW = 21,
	parameter int NYW = 20
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input side_t side,
	input logic [NXW-1:0] nx,
	input logic [NYW-1:0] ny,
	input logic [DIV_W-1:0] divx,
	input logic [DIV_W-1:0] divy,
	output logic q_valid,
	output side_t q_side,
	output logic [QW-1:0] qx,
	output logic [QW-1:0] qy
);

	typedef struct packed {
		logic [DIV_W-1:0] div;
		logic [DIV_W-1:0] r;
		logic [QW-1:0] d;
		logic [QW-1:0] q;
	} dst_t;

	// One restoring step: bring down dividend bit j, subtract if it fits.
	function automatic dst_t div_step(dst_t a, int j);
		dst_t o;
		logic [DIV_W:0] cand;
		o = a;
		cand = {a.r, a.d[j]};
		if (cand >= {1'b0, a.div}) begin
			o.r = DIV_W'(cand - {1'b0, a.div});
			o.q = {a.q[QW-2:0], 1'b1};
		end else begin
			o.r = cand[DIV_W-1:0];
			o.q = {a.q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	logic [NXW+7:0] dx;
	logic [NYW+7:0] dy;
	dst_t x_init;
	dst_t y_init;
	dst_t x_s [QW];
	dst_t y_s [QW];
	side_t side_s [QW];
	logic v_s [QW];

	// The quotient is known to fit in QW bits, so the bits above QW
	// are already below the divisor and form the first partial remainder.
	always_comb begin
		dx = {nx, 8'd0};
		dy = {ny, 8'd0};
		x_init.div = divx;
		x_init.r = DIV_W'(dx >> QW);
		x_init.d = dx[QW-1:0];
		x_init.q = '0;
		y_init.div = divy;
		y_init.r = DIV_W'(dy >> QW);
		y_init.d = dy[QW-1:0];
		y_init.q = '0;
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else begin
					v_s[i] <= valid;
				end
			end
			always_ff @(posedge clk) begin
				x_s[i] <= div_step(x_init, QW - 1 - i);
				y_s[i] <= div_step(y_init, QW - 1 - i);
				side_s[i] <= side;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[i] <= 1'b0;
				end else begin
					v_s[i] <= v_s[i-1];
				end
			end
			always_ff @(posedge clk) begin
				x_s[i] <= div_step(x_s[i-1], QW - 1 - i);
				y_s[i] <= div_step(y_s[i-1], QW - 1 - i);
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign q_valid = v_s[QW-1];
	assign q_side = side_s[QW-1];
	assign qx = x_s[QW-1].q;
	assign qy = y_s[QW-1].q;

endmodule

// File: hdl/bilinear_image_upscaler_core.sv
// Bilinear upscaler with an internal source image. One request (pixel write or
// output-pixel request) is taken every clock; busy never rises. A request's
// color appears on result with done high exactly once, after it passes
// stages 1 and 2, the pipelined coordinate divider and stages 3 to 7, where
// QW = max(clog2(SRC_WIDTH), clog2(SRC_HEIGHT)) + 8 is the number of stages
// of the divider (17 at the default size). The receiver cannot stall the
// result. Writes produce no result and take effect in order with requests.
// The source image lives in four banks split by row and column parity so
// that all four neighbors are read in the same cycle.
module bilinear_image_upscaler_core import biu_pkg::*; #(
	parameter int SRC_WIDTH = 320,
	parameter int SRC_HEIGHT = 240,
	parameter int MAX_OUT_DIM = 4096
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input item_t item,
	output logic done,
	output result_t result,
	input logic cfg_we,
	input logic cfg_index,
	input logic [DIM_W-1:0] cfg_data
);

	localparam int XW = $clog2(SRC_WIDTH);
	localparam int YW = $clog2(SRC_HEIGHT);
	localparam int QW = ((XW > YW) ? XW : YW) + 8;
	localparam int NXW = COORD_W + XW;
	localparam int NYW = COORD_W + YW;
	localparam int HW = (SRC_WIDTH + 1) / 2;
	localparam int HH = (SRC_HEIGHT + 1) / 2;
	localparam int DEPTH = HW * HH;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LAT = QW + 7;

	function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [8:0] f);
		logic signed [9:0] diff;
		logic signed [19:0] prod;
		logic signed [11:0] sum;
		diff = $signed({2'b00, b}) - $signed({2'b00, a});
		prod = diff * $signed({1'b0, f});
		sum = $signed({4'b0000, a}) + 12'(prod >>> 8);
		return sum[7:0];
	endfunction

	function automatic logic [DIV_W-1:0] size_limit(logic [DIM_W-1:0] size);
		logic [DIV_W-1:0] sz;
		if (size == '0) begin
			sz = DIV_W'(1);
		end else if (32'(size) > MAX_OUT_DIM) begin
			sz = DIV_W'(MAX_OUT_DIM);
		end else begin
			sz = size;
		end
		return sz - DIV_W'(1);
	endfunction

	logic accept;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_OUT_WIDTH;
			height_q <= RESET_OUT_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OUT_WIDTH: width_q <= cfg_data;
				CFG_OUT_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: saturate sizes and coordinates, spot the last column and row.
	logic [DIV_W-1:0] limx;
	logic [DIV_W-1:0] limy;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;

	always_comb begin
		limx = size_limit(width_q);
		limy = size_limit(height_q);
		cx = ({1'b0, item.out_col} > limx) ? limx[COORD_W-1:0] : item.out_col;
		cy = ({1'b0, item.out_row} > limy) ? limy[COORD_W-1:0] : item.out_row;
	end

	logic v_s1;
	side_t side_s1;
	logic [COORD_W-1:0] cx_s1;
	logic [COORD_W-1:0] cy_s1;
	logic [DIV_W-1:0] divx_s1;
	logic [DIV_W-1:0] divy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.kind <= item.kind;
		side_s1.src_col <= item.src_col;
		side_s1.src_row <= item.src_row;
		side_s1.pixel <= {item.red, item.green, item.blue};
		side_s1.lastx <= (limx != '0) && ({1'b0, cx} == limx);
		side_s1.lasty <= (limy != '0) && ({1'b0, cy} == limy);
		cx_s1 <= cx;
		cy_s1 <= cy;
		divx_s1 <= (limx == '0) ? DIV_W'(1) : limx;
		divy_s1 <= (limy == '0) ? DIV_W'(1) : limy;
	end

	// Stage 2: coordinate times (source size - 1).
	logic v_s2;
	side_t side_s2;
	logic [NXW-1:0] nx_s2;
	logic [NYW-1:0] ny_s2;
	logic [DIV_W-1:0] divx_s2;
	logic [DIV_W-1:0] divy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		nx_s2 <= NXW'(32'(cx_s1) * (SRC_WIDTH - 1));
		ny_s2 <= NYW'(32'(cy_s1) * (SRC_HEIGHT - 1));
		divx_s2 <= divx_s1;
		divy_s2 <= divy_s1;
	end

	logic m_valid;
	side_t m_side;
	logic [QW-1:0] qx;
	logic [QW-1:0] qy;

	biu_map #(
		.QW(QW),
		.NXW(NXW),
		.NYW(NYW)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.valid(v_s2),
		.side(side_s2),
		.nx(nx_s2),
		.ny(ny_s2),
		.divx(divx_s2),
		.divy(divy_s2),
		.q_valid(m_valid),
		.q_side(m_side),
		.qx(qx),
		.qy(qy)
	);

	// Stage 3: split the (QW-8).8 position into neighbor index and weight.
	logic v_s3;
	side_t side_s3;
	logic [XW-1:0] xi_s3;
	logic [YW-1:0] yi_s3;
	logic [8:0] fx_s3;
	logic [8:0] fy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= m_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= m_side;
		xi_s3 <= m_side.lastx ? XW'(SRC_WIDTH - 2) : qx[8 +: XW];
		yi_s3 <= m_side.lasty ? YW'(SRC_HEIGHT - 2) : qy[8 +: YW];
		fx_s3 <= m_side.lastx ? 9'd256 : {1'b0, qx[7:0]};
		fy_s3 <= m_side.lasty ? 9'd256 : {1'b0, qy[7:0]};
	end

	// Stage 4: bank addresses. Writes are issued at the same stage as reads,
	// so every request sees exactly the writes taken before it.
	logic req_s4;
	logic wen_s4;
	logic [1:0] wbank_s4;
	logic [AW-1:0] waddr_s4;
	logic [PIX_W-1:0] wdata_s4;
	logic px_s4;
	logic py_s4;
	logic [8:0] fx_s4;
	logic [8:0] fy_s4;
	logic [AW-1:0] raddr_s4 [4];
	logic [3:0] bank_we;
	logic [PIX_W-1:0] rd [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s4 <= 1'b0;
			wen_s4 <= 1'b0;
		end else begin
			req_s4 <= v_s3 && (side_s3.kind == KIND_REQUEST);
			wen_s4 <= v_s3 && (side_s3.kind == KIND_WRITE)
				&& (32'(side_s3.src_col) < SRC_WIDTH)
				&& (32'(side_s3.src_row) < SRC_HEIGHT);
		end
	end

	always_ff @(posedge clk) begin
		wbank_s4 <= {side_s3.src_row[0], side_s3.src_col[0]};
		waddr_s4 <= AW'(32'(side_s3.src_row >> 1) * HW + 32'(side_s3.src_col >> 1));
		wdata_s4 <= side_s3.pixel;
		px_s4 <= xi_s3[0];
		py_s4 <= yi_s3[0];
		fx_s4 <= fx_s3;
		fy_s4 <= fy_s3;
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam bit RX = (b % 2) == 1;
		localparam bit RY = b >= 2;
		logic [XW-1:0] ch;
		logic [YW-1:0] rh;

		// Of the two neighbor columns, the odd one is xi/2 and the even one
		// is (xi+1)/2; rows likewise.
		always_comb begin
			ch = RX ? (xi_s3 >> 1) : (XW'(xi_s3 + XW'(1)) >> 1);
			rh = RY ? (yi_s3 >> 1) : (YW'(yi_s3 + YW'(1)) >> 1);
		end

		always_ff @(posedge clk) begin
			raddr_s4[b] <= AW'(32'(rh) * HW + 32'(ch));
		end

		assign bank_we[b] = wen_s4 && (wbank_s4 == 2'(b));

		biu_ram #(
			.WIDTH(PIX_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk(clk),
			.we(bank_we[b]),
			.waddr(waddr_s4),
			.wdata(wdata_s4),
			.raddr(raddr_s4[b]),
			.rdata(rd[b])
		);
	end

	// Stage 5: memory read data arrives.
	logic req_s5;
	logic px_s5;
	logic py_s5;
	logic [8:0] fx_s5;
	logic [8:0] fy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s5 <= 1'b0;
		end else begin
			req_s5 <= req_s4;
		end
	end

	always_ff @(posedge clk) begin
		px_s5 <= px_s4;
		py_s5 <= py_s4;
		fx_s5 <= fx_s4;
		fy_s5 <= fy_s4;
	end

	// Stage 6: horizontal blend on both rows.
	logic [PIX_W-1:0] p00;
	logic [PIX_W-1:0] p01;
	logic [PIX_W-1:0] p10;
	logic [PIX_W-1:0] p11;

	always_comb begin
		p00 = rd[{py_s5, px_s5}];
		p01 = rd[{py_s5, ~px_s5}];
		p10 = rd[{~py_s5, px_s5}];
		p11 = rd[{~py_s5, ~px_s5}];
	end

	logic req_s6;
	logic [8:0] fy_s6;
	logic [7:0] t0_s6 [3];
	logic [7:0] t1_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s6 <= 1'b0;
		end else begin
			req_s6 <= req_s5;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_chan
		localparam int SH = 16 - 8 * k;
		always_ff @(posedge clk) begin
			t0_s6[k] <= blend(p00[SH +: 8], p01[SH +: 8], fx_s5);
			t1_s6[k] <= blend(p10[SH +: 8], p11[SH +: 8], fx_s5);
		end
	end

	always_ff @(posedge clk) begin
		fy_s6 <= fy_s5;
	end

	// Stage 7: vertical blend into the result register.
	logic done_s7;
	result_t res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= req_s6;
		end
	end

	always_ff @(posedge clk) begin
		res_s7.out_red <= blend(t0_s6[0], t1_s6[0], fy_s6);
		res_s7.out_green <= blend(t0_s6[1], t1_s6[1], fy_s6);
		res_s7.out_blue <= blend(t0_s6[2], t1_s6[2], fy_s6);
	end

	assign done = done_s7;
	assign result = res_s7;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (item.kind == KIND_REQUEST), LAT))
		else $error("result without a matching request");

	a_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		wen_s4 |-> (32'(waddr_s4) < DEPTH))
		else $error("pixel write beyond bank depth");

	a_bank: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bank_we))
		else $error("pixel write hits more than one bank");

endmodule
